// ----- rtl/core/fdl_pkg.sv -----
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared types, constants and helpers of the feedback delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

    // Sample format: Q1.15 two's complement
    localparam int SAMPLE_W   = 16;
    // Width of the delay and gain registers
    localparam int DELAY_W    = 15;
    localparam int GAIN_W     = 15;
    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYPASS = 2'd0,
        CFG_DELAY  = 2'd1,
        CFG_GAIN   = 2'd2
    } t_cfg_idx;

    // Clamp a widened sum back to the sample range
    function automatic t_sample sat16(input logic signed [18:0] v);
        if (v > 19'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -19'sd32768) begin
            return 16'sh8000;
        end
        return t_sample'(v[SAMPLE_W-1:0]);
    endfunction

endpackage

// ----- rtl/core/fdl_in_if.sv -----
// ----------------------------------------------------------------------------
// fdl_in_if
// Input frame stream: valid/ready handshake with one sample per side.
// ----------------------------------------------------------------------------
interface fdl_in_if;
    import fdl_pkg::*;

    logic    valid;
    logic    ready;
    t_sample in_left;
    t_sample in_right;

    modport source (output valid, output in_left, output in_right, input ready);
    modport sink   (input valid, input in_left, input in_right, output ready);
endinterface

// ----- rtl/core/fdl_out_if.sv -----
// ----------------------------------------------------------------------------
// fdl_out_if
// Output frame stream: valid/ready handshake with one sample per side.
// ----------------------------------------------------------------------------
interface fdl_out_if;
    import fdl_pkg::*;

    logic    valid;
    logic    ready;
    t_sample out_left;
    t_sample out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ----- rtl/core/fdl_ram.sv -----
// ----------------------------------------------------------------------------
// fdl_ram
// Simple dual-port RAM: one write port, one read port, registered read data
// (read returns the old contents on a same-address write).
// ----------------------------------------------------------------------------
module fdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32768
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/core/feedback_delay_line.sv -----
// ----------------------------------------------------------------------------
// feedback_delay_line
// Multichannel feedback comb (echo) delay on a circular sample store in RAM.
//
//   channel   dir  handshake          payload
//   i_frame   in   valid/ready        in_left, in_right (Q1.15)
//   o_frame   out  valid/ready        out_left, out_right (Q1.15)
//   cfg       in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// The single RAM read port fetches the read slot in the accept cycle and the
// write slot in the next, so a new frame is not taken during the write fetch.
// Reset starts a clearing pass over all DELAY_DEPTH rows with i_frame.ready low.
// A delay register write holds ready low while the reciprocal modulo
// reduction runs (quotient, then subtract); later register writes pause it.
// A 2-entry output queue lets frames enter while results wait downstream.
// ----------------------------------------------------------------------------
module feedback_delay_line #(
    parameter int DELAY_DEPTH = 32768,
    parameter int CHANNELS    = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    fdl_in_if.sink                           i_frame,
    fdl_out_if.source                        o_frame
);
    import fdl_pkg::*;

    localparam int AW        = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int RW        = SAMPLE_W * CHANNELS;
    localparam int DW        = AW + 1 + DELAY_W;
    localparam int RED_STEPS = 2;
    localparam int RCW       = $clog2(RED_STEPS + 1);
    localparam int RED_SH    = DELAY_W + AW;
    localparam int PW        = 2 * DELAY_W + 2;
    // ceil(2^RED_SH / DELAY_DEPTH): exact floor division for 15-bit delays
    localparam longint RECIP_L = ((longint'(1) << RED_SH) + longint'(DELAY_DEPTH) - 1)
                                 / longint'(DELAY_DEPTH);
    localparam logic [DELAY_W+1:0] RECIP    = (DELAY_W+2)'(RECIP_L);
    localparam logic [DELAY_W-1:0] DEPTH_LO = DELAY_W'(DELAY_DEPTH);
    localparam logic [AW:0]    DEPTH_W   = (AW+1)'(DELAY_DEPTH);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(DELAY_DEPTH - 1);

    // Clearing pass
    logic                r_clr;
    logic [AW-1:0]       r_clr_addr;

    // Configuration and delay offset reduction
    logic                r_bypass;
    logic [GAIN_W-1:0]   r_gain;
    logic [DELAY_W-1:0]  r_dm;
    logic [DELAY_W-1:0]  r_quo;
    logic [RCW-1:0]      r_red_cnt;

    // Read position
    logic [AW-1:0]       r_rp;

    // Fetch stage (read slot data arrives)
    logic                r_b_valid;
    t_sample             r_b_in_l;
    t_sample             r_b_in_r;
    logic                r_b_fwd;
    logic [RW-1:0]       r_b_fwd_row;

    // Update stage (write slot data arrives)
    logic                r_c_valid;
    logic                r_c_bypass;
    t_sample             r_c_x [CHANNELS];
    logic signed [31:0]  r_c_prod [CHANNELS];
    logic [AW-1:0]       r_c_wp;
    logic                r_c_zero;

    // Output queue
    logic [2*SAMPLE_W-1:0] r_q [2];
    logic                  r_q_wr;
    logic                  r_q_rd;
    logic [1:0]            r_q_cnt;

    // Combinational
    logic                in_acc;
    logic                out_acc;
    logic                ready;
    logic [AW:0]         rp_inc;
    logic [AW-1:0]       rp_next;
    logic [DW-1:0]       dm_ext;
    logic [PW-1:0]       red_prod;
    logic [DELAY_W-1:0]  red_quo;
    logic [AW:0]         wp_sum;
    logic [AW:0]         wp_wrap;
    logic [AW-1:0]       wp;
    logic [RW-1:0]       y_row;
    t_sample             y_s [CHANNELS];
    t_sample             x_s [CHANNELS];
    t_sample             y_right;
    logic [RW-1:0]       wr_row;
    logic                fwd_hit;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [RW-1:0]       mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [RW-1:0]       mem_rdata;
    t_sample             res_l;
    t_sample             res_r;

    // Handshakes
    assign ready         = !r_clr && !r_b_valid && (r_red_cnt == '0) && (r_q_cnt != 2'd2);
    assign i_frame.ready = ready;
    assign in_acc        = i_frame.valid && ready;
    assign o_frame.valid = (r_q_cnt != 2'd0);
    assign out_acc       = o_frame.valid && o_frame.ready;
    assign o_frame.out_left  = t_sample'(r_q[r_q_rd][2*SAMPLE_W-1:SAMPLE_W]);
    assign o_frame.out_right = t_sample'(r_q[r_q_rd][SAMPLE_W-1:0]);

    // Delay quotient by reciprocal multiplication
    assign red_prod = PW'(r_dm) * PW'(RECIP);
    assign red_quo  = DELAY_W'(red_prod >> RED_SH);

    // Read position advance and write position (one compare-subtract wrap)
    assign rp_inc  = {1'b0, r_rp} + (AW+1)'(1);
    assign rp_next = (rp_inc == DEPTH_W) ? '0 : rp_inc[AW-1:0];
    assign dm_ext  = DW'(r_dm);
    assign wp_sum  = {1'b0, r_rp} + dm_ext[AW:0];
    assign wp_wrap = (wp_sum >= DEPTH_W) ? (wp_sum - DEPTH_W) : wp_sum;
    assign wp      = wp_wrap[AW-1:0];

    // Delayed samples, with forwarding of a same-cycle write
    assign y_row = r_b_fwd ? r_b_fwd_row : mem_rdata;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            y_s[c] = t_sample'(y_row[c*SAMPLE_W +: SAMPLE_W]);
            if (c == 0) begin
                x_s[c] = r_b_in_l;
            end else if (c == 1) begin
                x_s[c] = r_b_in_r;
            end else begin
                x_s[c] = '0;
            end
        end
    end

    generate
        if (CHANNELS > 1) begin : g_right
            assign y_right = y_s[1];
        end else begin : g_no_right
            assign y_right = '0;
        end
    endgenerate

    assign res_l = r_bypass ? r_b_in_l : y_s[0];
    assign res_r = r_bypass ? r_b_in_r : y_right;

    // Accumulate into the write slot: old + x + round(y * gain)
    always_comb begin
        logic signed [31:0] fb;
        t_sample            old;
        logic signed [18:0] sum;
        for (int c = 0; c < CHANNELS; c++) begin
            fb  = (r_c_prod[c] + 32'sd16384) >>> 15;
            old = r_c_zero ? '0 : t_sample'(mem_rdata[c*SAMPLE_W +: SAMPLE_W]);
            sum = 19'(old) + 19'(r_c_x[c]) + 19'($signed(fb[16:0]));
            wr_row[c*SAMPLE_W +: SAMPLE_W] = sat16(sum);
        end
    end

    // Write slot of the item in update equals the next read slot
    assign fwd_hit = r_c_valid && !r_c_bypass && (r_c_wp == r_rp);

    // RAM port steering: clear pass, read-slot clear, write-slot update
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        if (r_clr) begin
            mem_we = 1'b1;
        end else if (r_b_valid && !r_bypass) begin
            mem_we    = 1'b1;
            mem_waddr = r_rp;
        end else if (r_c_valid && !r_c_bypass) begin
            mem_we    = 1'b1;
            mem_waddr = r_c_wp;
            mem_wdata = wr_row;
        end
    end

    assign mem_re    = in_acc || r_b_valid;
    assign mem_raddr = r_b_valid ? wp : r_rp;

    fdl_ram #(
        .WIDTH (RW),
        .DEPTH (DELAY_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_bypass   <= 1'b0;
            r_gain     <= '0;
            r_dm       <= DELAY_W'(1);
            r_quo      <= '0;
            r_red_cnt  <= '0;
            r_rp       <= '0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_q_wr     <= 1'b0;
            r_q_rd     <= 1'b0;
            r_q_cnt    <= '0;
        end else begin
            // clearing pass, one row per cycle
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr <= 1'b0;
                end
            end

            // configuration writes; a delay write restarts the reduction
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_BYPASS: r_bypass <= i_cfg_data[0];
                    CFG_DELAY: begin
                        r_dm      <= i_cfg_data[DELAY_W-1:0];
                        r_red_cnt <= RCW'(RED_STEPS);
                    end
                    CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end else if (r_red_cnt != '0) begin
                // delay modulo depth: quotient first, then one subtract
                if (r_red_cnt == RCW'(RED_STEPS)) begin
                    r_quo <= red_quo;
                end else begin
                    r_dm <= r_dm - r_quo * DEPTH_LO;
                end
                r_red_cnt <= r_red_cnt - RCW'(1);
            end

            // pipeline valids
            r_b_valid <= in_acc;
            r_c_valid <= r_b_valid;

            // read position moves once per frame processed outside bypass
            if (r_b_valid && !r_bypass) begin
                r_rp <= rp_next;
            end

            // output queue
            if (r_b_valid) begin
                r_q_wr <= ~r_q_wr;
            end
            if (out_acc) begin
                r_q_rd <= ~r_q_rd;
            end
            if (r_b_valid && !out_acc) begin
                r_q_cnt <= r_q_cnt + 2'd1;
            end else if (!r_b_valid && out_acc) begin
                r_q_cnt <= r_q_cnt - 2'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b_in_l    <= i_frame.in_left;
            r_b_in_r    <= i_frame.in_right;
            r_b_fwd     <= fwd_hit;
            r_b_fwd_row <= wr_row;
        end
        if (r_b_valid) begin
            r_c_bypass <= r_bypass;
            r_c_wp     <= wp;
            r_c_zero   <= (wp == r_rp);
            for (int c = 0; c < CHANNELS; c++) begin
                r_c_x[c]    <= x_s[c];
                r_c_prod[c] <= 32'(y_s[c]) * 32'($signed({1'b0, r_gain}));
            end
            r_q[r_q_wr] <= {res_l, res_r};
        end
    end

endmodule

// ----- rtl/core/fdl_checker.sv -----
// ----------------------------------------------------------------------------
// fdl_checker
// Port-level checks of the feedback delay line, bound to the top level.
// ----------------------------------------------------------------------------
module fdl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_left,
    input logic [15:0] i_out_right
);
    logic [2:0] r_pending;
    logic       r_rst_seen;

    // Frames accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 3'(i_in_valid && i_in_ready)
                                   - 3'(i_out_valid && i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rst_seen <= 1'b1;
        end
    end

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_left) && $stable(i_out_right))
        else $error("stalled result changed");

    // No result without a frame behind it
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 3'd0))
        else $error("result without accepted frame");

    // In flight plus queued never exceeds the output queue depth
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd2)
        else $error("too many frames outstanding");

    // Shared read port: frames are never accepted back to back
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("frames accepted back to back");

    // Clearing pass blocks input right after reset
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rst_seen && $past(!i_rst_n) |-> !i_in_ready)
        else $error("input taken during clearing pass");

endmodule

bind feedback_delay_line fdl_checker u_fdl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_frame.valid),
    .i_in_ready  (i_frame.ready),
    .i_out_valid (o_frame.valid),
    .i_out_ready (o_frame.ready),
    .i_out_left  (o_frame.out_left),
    .i_out_right (o_frame.out_right)
);
